@@ rtl/hmb_pkg.sv @@
package hmb_pkg;

  typedef enum logic [1:0] {
    CLS_FWD,
    CLS_BWD,
    CLS_SPLIT
  } cls_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PARA,
    F_TRANS,
    F_SQ,
    F_ROOT,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_MASS,
    B_DIV,
    B_FIN
  } back_state_e;

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [1:0] REG_AXIS_X = 2'd0;
  localparam logic [1:0] REG_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_AXIS_Z = 2'd2;

  localparam logic signed [15:0] AXIS_X_RESET = 16'sd0;
  localparam logic signed [15:0] AXIS_Y_RESET = 16'sd0;
  localparam logic signed [15:0] AXIS_Z_RESET = 16'sd16384;

  // One classified particle, as handed from front to back
  typedef struct packed {
    logic signed [23:0] mom_x;
    logic signed [23:0] mom_y;
    logic signed [23:0] mom_z;
    logic [23:0]        energy;
    logic               last;
    cls_e               cls;
    logic [31:0]        trans;
    logic [24:0]        pmag;
  } part_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // State of one bit-per-step square root
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } root_t;

endpackage

@@ rtl/hmb_in_if.sv @@
interface hmb_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] mom_x;
  logic signed [23:0] mom_y;
  logic signed [23:0] mom_z;
  logic [23:0]        energy;
  logic               last;

  modport source (output valid, output mom_x, output mom_y, output mom_z,
                  output energy, output last, input ready);
  modport sink (input valid, input mom_x, input mom_y, input mom_z,
                input energy, input last, output ready);
endinterface

@@ rtl/hmb_out_if.sv @@
interface hmb_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        visible_energy_sq;
  logic signed [63:0] mass_sq_high;
  logic signed [63:0] mass_sq_low;
  logic [15:0]        broad_high;
  logic [15:0]        broad_low;
  logic               heavy_is_broad;
  logic               empty_event;

  modport source (output valid, output visible_energy_sq, output mass_sq_high,
                  output mass_sq_low, output broad_high, output broad_low,
                  output heavy_is_broad, output empty_event, input ready);
  modport sink (input valid, input visible_energy_sq, input mass_sq_high,
                input mass_sq_low, input broad_high, input broad_low,
                input heavy_is_broad, input empty_event, output ready);
endinterface

@@ rtl/hemisphere_mass_broadening.sv @@
// Hemisphere masses and jet broadening. Send one event's particles on in_i,
// one four-momentum per request (signed Q8 momenta, unsigned Q8 energy), and
// mark the final particle with last; res_o then carries one result for the
// event: visible energy squared, the larger and smaller hemisphere mass
// squared (Q16, saturating), the larger and smaller broadening (Q0.16), and
// the heavy-is-broad and empty-event flags. Sums clear after each result.
// The hemisphere axis is a Q2.14 vector on the APB port (axis_x at 0x0,
// axis_y at 0x4, axis_z at 0x8) and is used as written; write it only
// between events. In the front stage each particle passes through these steps:
// taking the request, three projection products, three transverse rounding
// and squaring pairs, a 32-step square root for both the transverse and the
// full momentum, and the hand-off to the queue, which waits while it is full.
// The back stage adds each particle to the sums as it pops it; after the
// last particle it computes nine squares through one shared 18x18 multiplier,
// the mass subtraction and a 16-step division for the broadenings, while the
// front goes on taking the next event's particles into the queue.
module hemisphere_mass_broadening #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hmb_in_if.sink      in_i,
  hmb_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hmb_pkg::*;

  logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
  logic               cfg_we;
  part_t              front_part, back_part;
  q_stat_t            q_stat;
  logic               q_push, q_pop;

  // Register file: write on the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q <= AXIS_X_RESET;
      axis_y_q <= AXIS_Y_RESET;
      axis_z_q <= AXIS_Z_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_AXIS_X: axis_x_q <= pwdata[15:0];
        REG_AXIS_Y: axis_y_q <= pwdata[15:0];
        REG_AXIS_Z: axis_z_q <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back sign-extended; unmapped addresses read zero
  always_comb begin
    unique case (paddr[3:2])
      REG_AXIS_X: prdata = 32'(axis_x_q);
      REG_AXIS_Y: prdata = 32'(axis_y_q);
      REG_AXIS_Z: prdata = 32'(axis_z_q);
      default:    prdata = '0;
    endcase
  end

  // Front: project, split off the transverse part, take both roots
  hmb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .axis_x_i (axis_x_q),
    .axis_y_i (axis_y_q),
    .axis_z_i (axis_z_q),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .part_o   (front_part)
  );

  // Queue decouples per-particle work from event finalization
  hmb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_part),
    .pop_i  (q_pop),
    .data_o (back_part),
    .stat_o (q_stat)
  );

  // Back: accumulate hemispheres, finalize on the last particle
  hmb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .part_i   (back_part),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .res_o    (res_o)
  );

endmodule

@@ rtl/hmb_front.sv @@
module hmb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  hmb_in_if.sink             in_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  hmb_pkg::q_stat_t   q_stat_i,
  output logic               push_o,
  output hmb_pkg::part_t     part_o
);
  import hmb_pkg::*;

  front_state_e state_q, state_d;

  logic signed [23:0] p_q [3];
  logic signed [23:0] p_d [3];
  logic [23:0]        e_q, e_d;
  logic               last_q, last_d;
  logic [1:0]         idx_q, idx_d;
  logic signed [40:0] para_q, para_d;
  logic [29:0]        r_q, r_d;
  logic [63:0]        tsq_q, tsq_d, psq_q, psq_d;
  root_t              troot_q, troot_d, proot_q, proot_d;
  logic [63:0]        bit_q, bit_d;
  logic [4:0]         cnt_q, cnt_d;

  logic signed [23:0] p_sel;
  logic signed [15:0] ax_sel;
  logic signed [39:0] prod_para;
  logic signed [56:0] prod_t;
  logic signed [57:0] t_full;
  logic [57:0]        t_mag, t_rnd;
  logic [59:0]        r_sq;
  logic [23:0]        p_mag;
  logic [47:0]        p_sq;
  logic [63:0]        tsq_n, psq_n;

  function automatic root_t root_step(root_t s, logic [63:0] b);
    root_t o;
    o = s;
    if (s.v >= s.r + b) begin
      o.v = s.v - (s.r + b);
      o.r = (s.r >> 1) + b;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  always_comb begin
    unique case (idx_q)
      2'd0: begin
        p_sel  = p_q[0];
        ax_sel = axis_x_i;
      end
      2'd1: begin
        p_sel  = p_q[1];
        ax_sel = axis_y_i;
      end
      default: begin
        p_sel  = p_q[2];
        ax_sel = axis_z_i;
      end
    endcase
  end

  assign prod_para = p_sel * ax_sel;
  assign prod_t    = para_q * ax_sel;
  assign t_full    = (58'(p_sel) <<< 28) - 58'(prod_t);
  assign t_mag     = t_full[57] ? 58'(-t_full) : 58'(t_full);
  assign t_rnd     = t_mag + (58'd1 << 27);
  assign r_sq      = r_q * r_q;
  assign p_mag     = p_sel[23] ? 24'(-p_sel) : 24'(p_sel);
  assign p_sq      = p_mag * p_mag;
  assign tsq_n     = tsq_q + 64'(r_sq);
  assign psq_n     = psq_q + 64'(p_sq);

  // Datapath
  always_comb begin
    p_d     = p_q;
    e_d     = e_q;
    last_d  = last_q;
    idx_d   = idx_q;
    para_d  = para_q;
    r_d     = r_q;
    tsq_d   = tsq_q;
    psq_d   = psq_q;
    troot_d = troot_q;
    proot_d = proot_q;
    bit_d   = bit_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          p_d[0] = in_i.mom_x;
          p_d[1] = in_i.mom_y;
          p_d[2] = in_i.mom_z;
          e_d    = in_i.energy;
          last_d = in_i.last;
          idx_d  = 2'd0;
          para_d = '0;
          tsq_d  = '0;
          psq_d  = '0;
        end
      end
      F_PARA: begin
        para_d = para_q + 41'(prod_para);
        idx_d  = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end
      F_TRANS: begin
        r_d = t_rnd[57:28];
      end
      F_SQ: begin
        tsq_d = tsq_n;
        psq_d = psq_n;
        idx_d = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          troot_d.v = tsq_n;
          troot_d.r = '0;
          proot_d.v = psq_n;
          proot_d.r = '0;
          bit_d     = 64'd1 << 62;
          cnt_d     = '0;
        end
      end
      F_ROOT: begin
        troot_d = root_step(troot_q, bit_q);
        proot_d = root_step(proot_q, bit_q);
        bit_d   = bit_q >> 2;
        cnt_d   = cnt_q + 5'd1;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_i.valid) state_d = F_PARA;
      F_PARA:  if (idx_q == 2'd2) state_d = F_TRANS;
      F_TRANS: state_d = F_SQ;
      F_SQ:    state_d = (idx_q == 2'd2) ? F_ROOT : F_TRANS;
      F_ROOT:  if (cnt_q == 5'd31) state_d = F_PUSH;
      F_PUSH:  if (!q_stat_i.full) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_i.ready    = (state_q == F_IDLE);
    push_o        = (state_q == F_PUSH) && !q_stat_i.full;
    part_o.mom_x  = p_q[0];
    part_o.mom_y  = p_q[1];
    part_o.mom_z  = p_q[2];
    part_o.energy = e_q;
    part_o.last   = last_q;
    part_o.trans  = troot_q.r[31:0];
    part_o.pmag   = proot_q.r[24:0];
    if (para_q == '0) begin
      part_o.cls = CLS_SPLIT;
    end else if (para_q[40]) begin
      part_o.cls = CLS_BWD;
    end else begin
      part_o.cls = CLS_FWD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    e_q     <= e_d;
    last_q  <= last_d;
    idx_q   <= idx_d;
    para_q  <= para_d;
    r_q     <= r_d;
    tsq_q   <= tsq_d;
    psq_q   <= psq_d;
    troot_q <= troot_d;
    proot_q <= proot_d;
    bit_q   <= bit_d;
    cnt_q   <= cnt_d;
  end

endmodule

@@ rtl/hmb_fifo.sv @@
module hmb_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hmb_pkg::part_t   data_i,
  input  logic             pop_i,
  output hmb_pkg::part_t   data_o,
  output hmb_pkg::q_stat_t stat_o
);
  import hmb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  part_t         mem_q [DEPTH];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]   cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  assign data_o       = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == (AW + 1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW + 1)'(DEPTH))
    else $error("queue fill count out of range");

endmodule

@@ rtl/hmb_back.sv @@
module hmb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hmb_pkg::part_t   part_i,
  input  hmb_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  hmb_out_if.source        res_o
);
  import hmb_pkg::*;

  back_state_e state_q, state_d;

  logic signed [35:0] fwd_q [4];
  logic signed [35:0] fwd_d [4];
  logic signed [35:0] bwd_q [4];
  logic signed [35:0] bwd_d [4];
  logic [34:0]        esum_q, esum_d;
  logic [35:0]        tf_q, tf_d, tb_q, tb_d;
  logic [36:0]        nsum_q, nsum_d;

  logic [71:0]        sq_q [9];
  logic [71:0]        sq_d [9];
  logic [3:0]         sq_idx_q, sq_idx_d;
  logic [1:0]         part_q, part_d;
  logic [71:0]        acc_q, acc_d;

  logic [63:0]        vis_q, vis_d;
  logic signed [63:0] mf_q, mf_d, mb_q, mb_d;
  logic [36:0]        rf_q, rf_d, rb_q, rb_d;
  logic [15:0]        qf_q, qf_d, qb_q, qb_d;
  logic [3:0]         div_cnt_q, div_cnt_d;

  logic               rv_q, rv_d;
  logic [63:0]        r_vis_q, r_vis_d;
  logic signed [63:0] r_mh_q, r_mh_d, r_ml_q, r_ml_d;
  logic [15:0]        r_bh_q, r_bh_d, r_bl_q, r_bl_d;
  logic               r_hb_q, r_hb_d, r_ee_q, r_ee_d;

  logic signed [24:0] v_in [4];
  logic signed [24:0] h_in [4];
  logic [35:0]        sq_op;
  logic [17:0]        mul_a, mul_b;
  logic [35:0]        mul_p;
  logic [71:0]        acc_n;
  logic [37:0]        rs_f, rs_b, nsum_x;
  logic [15:0]        bf, bb;
  logic               out_free;

  function automatic logic signed [35:0] sat_s(logic signed [35:0] a,
                                               logic signed [24:0] b);
    logic signed [36:0] s;
    s = 37'(a) + 37'(b);
    if (s[36] != s[35]) begin
      return s[36] ? {1'b1, 35'd0} : {1'b0, {35{1'b1}}};
    end
    return s[35:0];
  endfunction

  function automatic logic [35:0] mag36(logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

  function automatic logic signed [63:0] mass_sat(logic [71:0] e2, logic [71:0] a,
                                                  logic [71:0] b, logic [71:0] c);
    logic [73:0]        p2;
    logic signed [74:0] d;
    p2 = 74'(a) + 74'(b) + 74'(c);
    d  = $signed({3'b000, e2}) - $signed({1'b0, p2});
    if (d[74:63] == '0 || d[74:63] == '1) begin
      return d[63:0];
    end
    return d[74] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  // Hemisphere shares of the incoming particle
  always_comb begin
    v_in[0] = $signed({1'b0, part_i.energy});
    v_in[1] = 25'(part_i.mom_x);
    v_in[2] = 25'(part_i.mom_y);
    v_in[3] = 25'(part_i.mom_z);
    for (int k = 0; k < 4; k++) begin
      h_in[k] = v_in[k] >>> 1;
    end
  end

  // Shared squarer operand
  always_comb begin
    unique case (sq_idx_q)
      4'd0:    sq_op = 36'(esum_q);
      4'd1:    sq_op = mag36(fwd_q[0]);
      4'd2:    sq_op = mag36(fwd_q[1]);
      4'd3:    sq_op = mag36(fwd_q[2]);
      4'd4:    sq_op = mag36(fwd_q[3]);
      4'd5:    sq_op = mag36(bwd_q[0]);
      4'd6:    sq_op = mag36(bwd_q[1]);
      4'd7:    sq_op = mag36(bwd_q[2]);
      4'd8:    sq_op = mag36(bwd_q[3]);
      default: sq_op = '0;
    endcase
    unique case (part_q)
      2'd0: begin
        mul_a = sq_op[17:0];
        mul_b = sq_op[17:0];
      end
      2'd1: begin
        mul_a = sq_op[17:0];
        mul_b = sq_op[35:18];
      end
      default: begin
        mul_a = sq_op[35:18];
        mul_b = sq_op[35:18];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (part_q)
      2'd0:    acc_n = 72'(mul_p);
      2'd1:    acc_n = acc_q + (72'(mul_p) << 19);
      default: acc_n = acc_q + (72'(mul_p) << 36);
    endcase
  end

  assign nsum_x = {1'b0, nsum_q};
  assign rs_f   = {rf_q, 1'b0};
  assign rs_b   = {rb_q, 1'b0};

  always_comb begin
    if (nsum_q == '0) begin
      bf = '0;
      bb = '0;
    end else begin
      bf = (tf_q >= 36'(nsum_q) && nsum_q[36] == 1'b0) ? 16'hFFFF : qf_q;
      bb = (tb_q >= 36'(nsum_q) && nsum_q[36] == 1'b0) ? 16'hFFFF : qb_q;
    end
  end

  assign out_free = !rv_q || res_o.ready;

  // Datapath
  always_comb begin
    fwd_d     = fwd_q;
    bwd_d     = bwd_q;
    esum_d    = esum_q;
    tf_d      = tf_q;
    tb_d      = tb_q;
    nsum_d    = nsum_q;
    sq_d      = sq_q;
    sq_idx_d  = sq_idx_q;
    part_d    = part_q;
    acc_d     = acc_q;
    vis_d     = vis_q;
    mf_d      = mf_q;
    mb_d      = mb_q;
    rf_d      = rf_q;
    rb_d      = rb_q;
    qf_d      = qf_q;
    qb_d      = qb_q;
    div_cnt_d = div_cnt_q;
    rv_d      = rv_q && !res_o.ready;
    r_vis_d   = r_vis_q;
    r_mh_d    = r_mh_q;
    r_ml_d    = r_ml_q;
    r_bh_d    = r_bh_q;
    r_bl_d    = r_bl_q;
    r_hb_d    = r_hb_q;
    r_ee_d    = r_ee_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          for (int k = 0; k < 4; k++) begin
            unique case (part_i.cls)
              CLS_FWD: fwd_d[k] = sat_s(fwd_q[k], v_in[k]);
              CLS_BWD: bwd_d[k] = sat_s(bwd_q[k], v_in[k]);
              default: begin
                fwd_d[k] = sat_s(fwd_q[k], h_in[k]);
                bwd_d[k] = sat_s(bwd_q[k], v_in[k] - h_in[k]);
              end
            endcase
          end
          begin : acc_sums
            logic [35:0] es;
            logic [36:0] ts_f, ts_b;
            logic [37:0] ns;
            es = 36'(esum_q) + 36'(part_i.energy);
            esum_d = es[35] ? '1 : es[34:0];
            ns = 38'(nsum_q) + 38'({part_i.pmag, 1'b0});
            nsum_d = ns[37] ? '1 : ns[36:0];
            unique case (part_i.cls)
              CLS_FWD: begin
                ts_f = 37'(tf_q) + 37'(part_i.trans);
                ts_b = 37'(tb_q);
              end
              CLS_BWD: begin
                ts_f = 37'(tf_q);
                ts_b = 37'(tb_q) + 37'(part_i.trans);
              end
              default: begin
                ts_f = 37'(tf_q) + 37'(part_i.trans >> 1);
                ts_b = 37'(tb_q) + 37'(part_i.trans - (part_i.trans >> 1));
              end
            endcase
            tf_d = ts_f[36] ? '1 : ts_f[35:0];
            tb_d = ts_b[36] ? '1 : ts_b[35:0];
          end
          sq_idx_d = '0;
          part_d   = '0;
        end
      end
      B_SQ: begin
        acc_d = acc_n;
        if (part_q == 2'd2) begin
          sq_d[sq_idx_q] = acc_n;
          part_d         = '0;
          sq_idx_d       = sq_idx_q + 4'd1;
        end else begin
          part_d = part_q + 2'd1;
        end
      end
      B_MASS: begin
        vis_d     = (sq_q[0][71:64] != '0) ? '1 : sq_q[0][63:0];
        mf_d      = mass_sat(sq_q[1], sq_q[2], sq_q[3], sq_q[4]);
        mb_d      = mass_sat(sq_q[5], sq_q[6], sq_q[7], sq_q[8]);
        rf_d      = 37'(tf_q);
        rb_d      = 37'(tb_q);
        qf_d      = '0;
        qb_d      = '0;
        div_cnt_d = '0;
      end
      B_DIV: begin
        if (rs_f >= nsum_x) begin
          rf_d = 37'(rs_f - nsum_x);
          qf_d = {qf_q[14:0], 1'b1};
        end else begin
          rf_d = rs_f[36:0];
          qf_d = {qf_q[14:0], 1'b0};
        end
        if (rs_b >= nsum_x) begin
          rb_d = 37'(rs_b - nsum_x);
          qb_d = {qb_q[14:0], 1'b1};
        end else begin
          rb_d = rs_b[36:0];
          qb_d = {qb_q[14:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 4'd1;
      end
      B_FIN: begin
        if (out_free) begin
          rv_d    = 1'b1;
          r_vis_d = vis_q;
          r_mh_d  = (mf_q >= mb_q) ? mf_q : mb_q;
          r_ml_d  = (mf_q >= mb_q) ? mb_q : mf_q;
          r_bh_d  = (bf >= bb) ? bf : bb;
          r_bl_d  = (bf >= bb) ? bb : bf;
          r_hb_d  = ((mf_q >= mb_q) == (bf >= bb));
          r_ee_d  = (nsum_q == '0);
          for (int k = 0; k < 4; k++) begin
            fwd_d[k] = '0;
            bwd_d[k] = '0;
          end
          esum_d = '0;
          tf_d   = '0;
          tb_d   = '0;
          nsum_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!q_stat_i.empty && part_i.last) state_d = B_SQ;
      B_SQ:    if (part_q == 2'd2 && sq_idx_q == 4'd8) state_d = B_MASS;
      B_MASS:  state_d = B_DIV;
      B_DIV:   if (div_cnt_q == 4'd15) state_d = B_FIN;
      B_FIN:   if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_o                   = (state_q == B_IDLE) && !q_stat_i.empty;
    res_o.valid             = rv_q;
    res_o.visible_energy_sq = r_vis_q;
    res_o.mass_sq_high      = r_mh_q;
    res_o.mass_sq_low       = r_ml_q;
    res_o.broad_high        = r_bh_q;
    res_o.broad_low         = r_bl_q;
    res_o.heavy_is_broad    = r_hb_q;
    res_o.empty_event       = r_ee_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      rv_q    <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        fwd_q[k] <= '0;
        bwd_q[k] <= '0;
      end
      esum_q  <= '0;
      tf_q    <= '0;
      tb_q    <= '0;
      nsum_q  <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      fwd_q   <= fwd_d;
      bwd_q   <= bwd_d;
      esum_q  <= esum_d;
      tf_q    <= tf_d;
      tb_q    <= tb_d;
      nsum_q  <= nsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    sq_idx_q  <= sq_idx_d;
    part_q    <= part_d;
    acc_q     <= acc_d;
    vis_q     <= vis_d;
    mf_q      <= mf_d;
    mb_q      <= mb_d;
    rf_q      <= rf_d;
    rb_q      <= rb_d;
    qf_q      <= qf_d;
    qb_q      <= qb_d;
    div_cnt_q <= div_cnt_d;
    r_vis_q   <= r_vis_d;
    r_mh_q    <= r_mh_d;
    r_ml_q    <= r_ml_d;
    r_bh_q    <= r_bh_d;
    r_bl_q    <= r_bl_d;
    r_hb_q    <= r_hb_d;
    r_ee_q    <= r_ee_d;
  end

endmodule

@@ bench/hemisphere_mass_broadening_tb.sv @@
module hemisphere_mass_broadening_tb;
  import hmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1900;
  // Slowest legal gap between two accepted requests: one particle through the
  // front stage and the back stage summary, the longest sender gap and the
  // longest receiver stall, taken several times.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 150;

  localparam longint FOUR_MAX = 64'sd34359738367;
  localparam longint FOUR_MIN = -64'sd34359738368;
  localparam longint unsigned ESUM_MAX = 64'd34359738367;
  localparam longint unsigned TSUM_MAX = 64'd68719476735;
  localparam longint unsigned NSUM_MAX = 64'd137438953471;

  typedef struct {
    logic [63:0]        vis_e_sq;
    logic signed [63:0] m_sq_hi;
    logic signed [63:0] m_sq_lo;
    logic [15:0]        b_hi;
    logic [15:0]        b_lo;
    logic               heavy_broad;
    logic               empty;
  } event_summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hmb_in_if  part_bus ();
  hmb_out_if summ_bus ();

  hemisphere_mass_broadening dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (part_bus.sink),
    .res_o   (summ_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Hemisphere accumulators and axis, mirrored from the block
  longint          axis_v[3];
  longint          fwd_four[4];
  longint          bwd_four[4];
  longint unsigned e_total;
  longint unsigned fwd_trans;
  longint unsigned bwd_trans;
  longint unsigned p_norm;

  event_summary_t summaries_due[$];

  int unsigned particles_sent = 0;
  int unsigned events_closed = 0;
  int unsigned summaries_seen = 0;
  int unsigned axis_writes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          send_no_gaps = 1'b0;
  bit          recv_no_stalls = 1'b0;
  int unsigned recv_stall = 0;

  // Every input starts at a known value
  initial begin
    part_bus.valid  = 1'b0;
    part_bus.mom_x  = '0;
    part_bus.mom_y  = '0;
    part_bus.mom_z  = '0;
    part_bus.energy = '0;
    part_bus.last   = 1'b0;
    summ_bus.ready  = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint sat_four(longint v);
    if (v > FOUR_MAX) return FOUR_MAX;
    if (v < FOUR_MIN) return FOUR_MIN;
    return v;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                             longint unsigned lim);
    longint unsigned s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic logic [127:0] square_wide(longint v);
    logic [127:0] m;
    m = {64'd0, abs64(v)};
    return m * m;
  endfunction

  // E^2 - |p|^2 of one hemisphere, clamped to the signed 64-bit range
  function automatic longint hemi_mass_sq(longint e, longint x, longint y, longint z);
    logic [127:0] e2;
    logic [127:0] p2;
    logic [127:0] d;
    e2 = square_wide(e);
    p2 = square_wide(x) + square_wide(y) + square_wide(z);
    if (e2 >= p2) begin
      d = e2 - p2;
      if (d > 128'h7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return longint'(d[63:0]);
    end
    d = p2 - e2;
    if (d >= 128'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return -longint'(d[63:0]);
  endfunction

  function automatic logic [15:0] hemi_broad(longint unsigned t, longint unsigned d);
    longint unsigned q;
    if (d == 0) return '0;
    q = (t << 16) / d;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic clear_hemispheres();
    for (int i = 0; i < 4; i++) begin
      fwd_four[i] = 0;
      bwd_four[i] = 0;
    end
    e_total = 0;
    fwd_trans = 0;
    bwd_trans = 0;
    p_norm = 0;
  endtask

  // Fold one accepted particle into the sums; on the closing particle queue
  // the event summary and clear.
  task automatic absorb_particle(logic [23:0] mx, logic [23:0] my, logic [23:0] mz,
                                 logic [23:0] en, logic lst);
    longint          p[4];
    longint          para;
    longint          t;
    longint          h;
    longint unsigned r;
    longint unsigned tsq;
    longint unsigned psq;
    longint unsigned trans;
    longint unsigned pmag;
    logic [127:0]    ev;
    longint          mf;
    longint          mb;
    logic [15:0]     bf;
    logic [15:0]     bb;
    event_summary_t  s;
    p[0] = longint'({40'd0, en});
    p[1] = longint'($signed(mx));
    p[2] = longint'($signed(my));
    p[3] = longint'($signed(mz));
    para = p[1] * axis_v[0] + p[2] * axis_v[1] + p[3] * axis_v[2];
    tsq = 0;
    psq = 0;
    for (int k = 0; k < 3; k++) begin
      t = p[k + 1] * (64'sd1 <<< 28) - para * axis_v[k];
      r = (abs64(t) + (64'd1 << 27)) >> 28;
      tsq = tsq + r * r;
      psq = psq + abs64(p[k + 1]) * abs64(p[k + 1]);
    end
    trans = floor_root(tsq);
    pmag = floor_root(psq);

    e_total = sat_sum(e_total, longint'(p[0]), ESUM_MAX);
    p_norm = sat_sum(p_norm, 2 * pmag, NSUM_MAX);

    if (para > 0) begin
      for (int i = 0; i < 4; i++) fwd_four[i] = sat_four(fwd_four[i] + p[i]);
      fwd_trans = sat_sum(fwd_trans, trans, TSUM_MAX);
    end else if (para < 0) begin
      for (int i = 0; i < 4; i++) bwd_four[i] = sat_four(bwd_four[i] + p[i]);
      bwd_trans = sat_sum(bwd_trans, trans, TSUM_MAX);
    end else begin
      // on the axis plane: forward takes the floor half, backward the rest
      for (int i = 0; i < 4; i++) begin
        h = p[i] >>> 1;
        fwd_four[i] = sat_four(fwd_four[i] + h);
        bwd_four[i] = sat_four(bwd_four[i] + (p[i] - h));
      end
      fwd_trans = sat_sum(fwd_trans, trans >> 1, TSUM_MAX);
      bwd_trans = sat_sum(bwd_trans, trans - (trans >> 1), TSUM_MAX);
    end

    if (lst) begin
      ev = {64'd0, e_total} * {64'd0, e_total};
      s.vis_e_sq = (ev[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : ev[63:0];
      mf = hemi_mass_sq(fwd_four[0], fwd_four[1], fwd_four[2], fwd_four[3]);
      mb = hemi_mass_sq(bwd_four[0], bwd_four[1], bwd_four[2], bwd_four[3]);
      bf = hemi_broad(fwd_trans, p_norm);
      bb = hemi_broad(bwd_trans, p_norm);
      s.m_sq_hi = (mf >= mb) ? mf : mb;
      s.m_sq_lo = (mf >= mb) ? mb : mf;
      s.b_hi = (bf >= bb) ? bf : bb;
      s.b_lo = (bf >= bb) ? bb : bf;
      s.heavy_broad = ((mf >= mb) == (bf >= bb));
      s.empty = (p_norm == 0);
      summaries_due = {summaries_due, s};
      events_closed++;
      clear_hemispheres();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one particle, hold it until the block takes the request, then
  // maybe drop valid for a random gap. Called and returns at a falling edge.
  task automatic send_particle(logic [23:0] mx, logic [23:0] my, logic [23:0] mz,
                               logic [23:0] en, logic lst);
    int unsigned gap;
    part_bus.mom_x  = mx;
    part_bus.mom_y  = my;
    part_bus.mom_z  = mz;
    part_bus.energy = en;
    part_bus.last   = lst;
    part_bus.valid  = 1'b1;
    do @(posedge clk); while (!part_bus.ready);
    absorb_particle(mx, my, mz, en, lst);
    particles_sent++;
    @(negedge clk);
    gap = send_no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      part_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_axis(logic [1:0] idx, logic signed [15:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{16{val[15]}}, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    axis_v[idx] = longint'(val);
    axis_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Let every summary drain, then give the back stage time to settle.
  task automatic wait_idle();
    part_bus.valid = 1'b0;
    while (summaries_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_axis(logic signed [15:0] ax, logic signed [15:0] ay,
                          logic signed [15:0] az);
    wait_idle();
    write_axis(REG_AXIS_X, ax);
    write_axis(REG_AXIS_Y, ay);
    write_axis(REG_AXIS_Z, az);
  endtask

  // Receiver: random stalls, with stretches of none
  always @(negedge clk) begin
    if (recv_stall != 0) begin
      summ_bus.ready = 1'b0;
      recv_stall--;
    end else begin
      summ_bus.ready = 1'b1;
      if (!recv_no_stalls && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Summary checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    event_summary_t s;
    if (summ_bus.valid && summ_bus.ready) begin
      summaries_seen++;
      if (summaries_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] summary with no event pending: vis=%h", $realtime,
                   summ_bus.visible_energy_sq);
      end else begin
        s = summaries_due.pop_front();
        if (summ_bus.visible_energy_sq !== s.vis_e_sq || summ_bus.mass_sq_high !== s.m_sq_hi ||
            summ_bus.mass_sq_low !== s.m_sq_lo || summ_bus.broad_high !== s.b_hi ||
            summ_bus.broad_low !== s.b_lo || summ_bus.heavy_is_broad !== s.heavy_broad ||
            summ_bus.empty_event !== s.empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] summary mismatch on event %0d", $realtime, summaries_seen);
            $display("  expected vis=%h mhi=%0d mlo=%0d bhi=%h blo=%h hb=%b em=%b",
                     s.vis_e_sq, s.m_sq_hi, s.m_sq_lo, s.b_hi, s.b_lo,
                     s.heavy_broad, s.empty);
            $display("  actual   vis=%h mhi=%0d mlo=%0d bhi=%h blo=%h hb=%b em=%b",
                     summ_bus.visible_energy_sq, summ_bus.mass_sq_high,
                     summ_bus.mass_sq_low, summ_bus.broad_high, summ_bus.broad_low,
                     summ_bus.heavy_is_broad, summ_bus.empty_event);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no accepted request on either channel
  always @(posedge clk) begin
    if ((part_bus.valid && part_bus.ready) || (summ_bus.valid && summ_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d summaries outstanding", summaries_due.size());
      $display("hemisphere_mass_broadening regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [23:0] rand_mom();
    case ($urandom_range(0, 11))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      2, 3:    return 24'h00_0000;
      4, 5, 6: return 24'($signed($urandom_range(0, 4000)) - 2000);
      7:       return 24'($signed($urandom_range(0, 400000)) - 200000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_energy();
    case ($urandom_range(0, 9))
      0:       return 24'hFF_FFFF;
      1:       return 24'h00_0000;
      2, 3, 4: return 24'($urandom_range(0, 5000));
      default: return 24'($urandom);
    endcase
  endfunction

  // One event of random particles, mostly short, a few long
  task automatic send_random_event();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 6);
    send_no_gaps = ($urandom_range(0, 5) == 0);
    recv_no_stalls = ($urandom_range(0, 5) == 0);
    for (int unsigned i = 0; i < n; i++)
      send_particle(rand_mom(), rand_mom(), rand_mom(), rand_energy(), i == n - 1);
  endtask

  task automatic test_directed();
    // all-zero particle: split between hemispheres, empty event
    send_particle(24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
    // extreme momenta and energy, on the axis and off it
    send_particle(24'h0, 24'h0, 24'h7F_FFFF, 24'hFF_FFFF, 1'b1);
    send_particle(24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h0, 1'b1);
    // odd values exactly on the plane, then a forward closer
    send_particle(24'd3, 24'd5, 24'd0, 24'd7, 1'b0);
    send_particle(-24'sd3, -24'sd1, 24'd0, 24'd1, 1'b0);
    send_particle(24'd0, 24'd0, 24'd1, 24'd2, 1'b1);
    // back-to-back pair, forward heavier
    send_particle(24'd100, 24'd0, 24'd500, 24'd600, 1'b0);
    send_particle(-24'sd100, 24'd0, -24'sd400, 24'd500, 1'b1);
    // massless forward, wide backward, large forward closer; then a large backward event
    send_particle(24'd0, 24'd0, 24'd1000, 24'd1000, 1'b0);
    send_particle(24'd900, 24'd900, -24'sd10, 24'd5, 1'b0);
    send_particle(24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 1'b1);
    send_particle(24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 1'b1);
  endtask

  // One large event that drives the output squares and masses into saturation
  task automatic test_saturation();
    send_no_gaps = 1'b1;
    for (int i = 0; i < 300; i++)
      send_particle(24'h0, 24'h0, 24'd1, 24'hFF_FFFF, 1'b0);
    for (int i = 0; i < 300; i++)
      send_particle(24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h0, i == 299);
    send_no_gaps = 1'b0;
  endtask

  task automatic test_axis_sweep();
    int unsigned budget;
    budget = (ITEM_TARGET - particles_sent) / 9;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_axis(16'sd16384, 16'sd0, 16'sd0);
        1: set_axis(16'sd0, -16'sd16384, 16'sd0);
        2: set_axis(16'sd0, 16'sd0, -16'sd16384);
        3: set_axis(16'sd11585, 16'sd0, 16'sd11585);
        4: set_axis(-16'sd16384, -16'sd16384, -16'sd16384);
        5: set_axis(16'sd16384, 16'sd16384, 16'sd16384);
        6: set_axis(16'sd0, 16'sd0, 16'sd0);
        7: set_axis(16'($signed($urandom_range(0, 32768)) - 16384),
                    16'($signed($urandom_range(0, 32768)) - 16384),
                    16'($signed($urandom_range(0, 32768)) - 16384));
        default: set_axis(16'sd0, 16'sd0, 16'sd16384);
      endcase
      for (int unsigned start = particles_sent; particles_sent < start + budget;)
        send_random_event();
    end
  endtask

  initial begin
    axis_v[0] = longint'(AXIS_X_RESET);
    axis_v[1] = longint'(AXIS_Y_RESET);
    axis_v[2] = longint'(AXIS_Z_RESET);
    clear_hemispheres();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_saturation();
    test_axis_sweep();

    wait_idle();
    $display("covered %0d particles in %0d events, %0d summaries checked, %0d axis writes",
             particles_sent, events_closed, summaries_seen, axis_writes);
    $display("axis settings: unit axes both signs, diagonal, all-max non-unit, zero, random");
    if (mismatches == 0) begin
      $display("hemisphere_mass_broadening regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("hemisphere_mass_broadening regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/hmb_pkg.sv
rtl/hmb_in_if.sv
rtl/hmb_out_if.sv
rtl/hmb_front.sv
rtl/hmb_fifo.sv
rtl/hmb_back.sv
rtl/hemisphere_mass_broadening.sv
bench/hemisphere_mass_broadening_tb.sv
